>>> hw/rtl/bero_pkg.sv
// ----------------------------------------------------------------------------
// bero_pkg
// Shared types and constants of the binary erosion block.
// ----------------------------------------------------------------------------
package bero_pkg;

    localparam int ELEM_MAX    = 8;
    localparam int ELEM_SH     = 3;
    localparam int WIN_BITS    = ELEM_MAX * ELEM_MAX;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0]  FG_VALUE = 8'hFF;
    localparam logic [7:0]  BG_VALUE = 8'h00;

    localparam logic [10:0] RST_IMAGE_COLS   = 11'd640;
    localparam logic [12:0] RST_IMAGE_ROWS   = 13'd480;
    localparam logic [3:0]  RST_ELEMENT_ROWS = 4'd3;
    localparam logic [3:0]  RST_ELEMENT_COLS = 4'd3;
    localparam logic [63:0] RST_ELEMENT_MASK = 64'h0000_0000_0007_0707;

    typedef enum logic [2:0] {
        CFG_IMAGE_COLS   = 3'd0,
        CFG_IMAGE_ROWS   = 3'd1,
        CFG_ELEMENT_ROWS = 3'd2,
        CFG_ELEMENT_COLS = 3'd3,
        CFG_ELEMENT_MASK = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    // context of one result on its way from the store read to the queue
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [ELEM_SH-1:0]  row_ofs;
        logic [ELEM_SH-1:0]  col_ofs;
        logic [WIN_BITS-1:0] emask;
        logic                oob;
        logic                fwd_lo;
        logic                fwd_hi;
        logic [2*ELEM_SH-1:0] fwd_idx;
        logic                fwd_val;
    } t_ctx;

    typedef struct packed {
        logic fg;
        logic last;
    } t_res;

endpackage

>>> hw/rtl/bero_ram.sv
// ----------------------------------------------------------------------------
// bero_ram
// Generic synchronous RAM: one bit-masked write port, two registered reads.
// ----------------------------------------------------------------------------
module bero_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wmask,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WIDTH; k++) begin
            if (i_we && i_wmask[k]) begin
                r_mem[i_waddr][k] <= i_wdata[k];
            end
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/bero_ctrl.sv
// ----------------------------------------------------------------------------
// bero_ctrl
// Configuration registers, input/output raster counters, result scheduling
// and store addressing.
// ----------------------------------------------------------------------------
module bero_ctrl #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [2:0]             i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_accept,
    input  logic                   i_kind,
    input  logic [7:0]             i_pixel,
    output logic                   o_we,
    output logic [$clog2((MAX_COLS-1)/bero_pkg::ELEM_MAX+2)-1:0] o_waddr,
    output logic [bero_pkg::WIN_BITS-1:0] o_wmask,
    output logic [bero_pkg::WIN_BITS-1:0] o_wdata,
    output logic [$clog2((MAX_COLS-1)/bero_pkg::ELEM_MAX+2)-1:0] o_raddr_a,
    output logic [$clog2((MAX_COLS-1)/bero_pkg::ELEM_MAX+2)-1:0] o_raddr_b,
    output bero_pkg::t_ctx         o_ctx
);

    localparam int EM    = bero_pkg::ELEM_MAX;
    localparam int SH    = bero_pkg::ELEM_SH;
    localparam int WB    = bero_pkg::WIN_BITS;
    localparam int DEPTH = (MAX_COLS - 1) / EM + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CXW   = CW + 1;
    localparam int RXW   = RW + 1;

    logic [10:0]    r_image_cols;
    logic [12:0]    r_image_rows;
    logic [3:0]     r_element_rows;
    logic [3:0]     r_element_cols;
    logic [63:0]    r_element_mask;

    logic [RIW-1:0] r_in_row,  n_in_row;
    logic [CIW-1:0] r_in_col,  n_in_col;
    logic           r_in_done, n_in_done;
    logic [RIW-1:0] r_out_row, n_out_row;
    logic [CIW-1:0] r_out_col, n_out_col;

    logic [CW-1:0]  cols;
    logic [RW-1:0]  rows;
    logic [3:0]     er;
    logic [3:0]     ec;
    logic           wr;
    logic [CW-1:0]  in_col_inc;
    logic [RW-1:0]  in_row_inc;
    logic [RXW-1:0] row_end;
    logic [CXW-1:0] col_end;
    logic [RIW-1:0] a_row;
    logic [CIW-1:0] b_col;
    logic           ready;
    logic           emit;
    logic           row_last;
    logic           col_last;
    logic           last;
    logic [EM-1:0]  row_out;
    logic [EM-1:0]  col_out;
    logic [WB-1:0]  emask;
    logic           oob;
    logic [AW-1:0]  wa;
    logic [AW-1:0]  ra_a;
    logic [AW-1:0]  ra_b;
    logic [2*SH-1:0] widx;
    logic           wval;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols   <= bero_pkg::RST_IMAGE_COLS;
            r_image_rows   <= bero_pkg::RST_IMAGE_ROWS;
            r_element_rows <= bero_pkg::RST_ELEMENT_ROWS;
            r_element_cols <= bero_pkg::RST_ELEMENT_COLS;
            r_element_mask <= bero_pkg::RST_ELEMENT_MASK;
        end else if (i_cfg_valid) begin
            case (bero_pkg::t_cfg_idx'(i_cfg_index))
                bero_pkg::CFG_IMAGE_COLS:   r_image_cols   <= i_cfg_data[10:0];
                bero_pkg::CFG_IMAGE_ROWS:   r_image_rows   <= i_cfg_data[12:0];
                bero_pkg::CFG_ELEMENT_ROWS: r_element_rows <= i_cfg_data[3:0];
                bero_pkg::CFG_ELEMENT_COLS: r_element_cols <= i_cfg_data[3:0];
                bero_pkg::CFG_ELEMENT_MASK: r_element_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped sizes
    always_comb begin
        if (r_image_cols == '0) begin
            cols = CW'(1);
        end else if (int'(r_image_cols) > MAX_COLS) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(r_image_cols);
        end
        if (r_image_rows == '0) begin
            rows = RW'(1);
        end else if (int'(r_image_rows) > MAX_ROWS) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_image_rows);
        end
        if (r_element_rows == '0) begin
            er = 4'd1;
        end else if (r_element_rows > 4'(EM)) begin
            er = 4'(EM);
        end else begin
            er = r_element_rows;
        end
        if (r_element_cols == '0) begin
            ec = 4'd1;
        end else if (r_element_cols > 4'(EM)) begin
            ec = 4'(EM);
        end else begin
            ec = r_element_cols;
        end
    end

    // input raster position
    assign wr         = i_accept && (i_kind == bero_pkg::KIND_PIXEL) && !r_in_done;
    assign in_col_inc = CW'(r_in_col) + CW'(1);
    assign in_row_inc = RW'(r_in_row) + RW'(1);

    // bottom-right corner of the window of the next result
    always_comb begin
        row_end = RXW'(r_out_row) + RXW'(er) - RXW'(1);
        col_end = CXW'(r_out_col) + CXW'(ec) - CXW'(1);
        a_row   = (row_end >= RXW'(rows)) ? RIW'(rows - RW'(1)) : RIW'(row_end);
        b_col   = (col_end >= CXW'(cols)) ? CIW'(cols - CW'(1)) : CIW'(col_end);
    end

    assign row_last = (RW'(r_out_row) + RW'(1)) >= rows;
    assign col_last = (CW'(r_out_col) + CW'(1)) >= cols;
    assign last     = row_last && col_last;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_in_done = r_in_done;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (wr) begin
            if (in_col_inc >= cols) begin
                n_in_col = '0;
                if (in_row_inc >= rows) begin
                    n_in_row  = '0;
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = RIW'(in_row_inc);
                end
            end else begin
                n_in_col = CIW'(in_col_inc);
            end
        end
        ready = n_in_done || (n_in_row > a_row) || (n_in_row == a_row && n_in_col > b_col);
        emit  = i_accept && ready;
        if (emit) begin
            if (last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_in_done = 1'b0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (col_last) begin
                n_out_col = '0;
                n_out_row = RIW'(RW'(r_out_row) + RW'(1));
            end else begin
                n_out_col = CIW'(CW'(r_out_col) + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_done <= 1'b0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_in_done <= n_in_done;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // element in use and image border test for the next result
    always_comb begin
        for (int m = 0; m < EM; m++) begin
            row_out[m] = (RXW'(r_out_row) + RXW'(m)) >= RXW'(rows);
            col_out[m] = (CXW'(r_out_col) + CXW'(m)) >= CXW'(cols);
        end
        oob = 1'b0;
        for (int m = 0; m < EM; m++) begin
            for (int n = 0; n < EM; n++) begin
                emask[m*EM+n] = r_element_mask[m*EM+n] && (4'(m) < er) && (4'(n) < ec);
                oob = oob | (emask[m*EM+n] & (row_out[m] | col_out[n]));
            end
        end
    end

    // store addressing: one word holds an aligned group of columns, all ring rows
    assign wa   = AW'(r_in_col >> SH);
    assign ra_a = AW'(r_out_col >> SH);
    assign ra_b = ra_a + AW'(1);
    assign widx = {r_in_row[SH-1:0], r_in_col[SH-1:0]};
    assign wval = |i_pixel;

    assign o_we      = wr;
    assign o_waddr   = wa;
    assign o_wmask   = WB'(1) << widx;
    assign o_wdata   = {WB{wval}};
    assign o_raddr_a = ra_a;
    assign o_raddr_b = ra_b;

    always_comb begin
        o_ctx.valid   = emit;
        o_ctx.last    = last;
        o_ctx.row_ofs = r_out_row[SH-1:0];
        o_ctx.col_ofs = r_out_col[SH-1:0];
        o_ctx.emask   = emask;
        o_ctx.oob     = oob;
        o_ctx.fwd_lo  = wr && (wa == ra_a);
        o_ctx.fwd_hi  = wr && (wa == ra_b);
        o_ctx.fwd_idx = widx;
        o_ctx.fwd_val = wval;
    end

endmodule

>>> hw/rtl/bero_eval.sv
// ----------------------------------------------------------------------------
// bero_eval
// Takes the two store words of a window, patches in a same-cycle write,
// aligns the window to the anchor and tests it against the element.
// ----------------------------------------------------------------------------
module bero_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bero_pkg::t_ctx                i_ctx,
    input  logic [bero_pkg::WIN_BITS-1:0] i_rdata_a,
    input  logic [bero_pkg::WIN_BITS-1:0] i_rdata_b,
    output logic                          o_busy,
    output logic                          o_push,
    output bero_pkg::t_res                o_res
);

    localparam int EM = bero_pkg::ELEM_MAX;
    localparam int SH = bero_pkg::ELEM_SH;
    localparam int WB = bero_pkg::WIN_BITS;

    bero_pkg::t_ctx  r_ctx;
    logic            r_valid;
    logic [2*WB-1:0] raw;
    logic [WB-1:0]   win;
    logic [SH-1:0]   ring;
    logic [2*EM-1:0] pair;
    logic [2*EM-1:0] shifted;

    always_ff @(posedge i_clk) begin
        r_ctx <= i_ctx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctx.valid;
        end
    end

    always_comb begin
        raw = {i_rdata_b, i_rdata_a};
        if (r_ctx.fwd_lo) begin
            raw[{1'b0, r_ctx.fwd_idx}] = r_ctx.fwd_val;
        end
        if (r_ctx.fwd_hi) begin
            raw[{1'b1, r_ctx.fwd_idx}] = r_ctx.fwd_val;
        end
        ring    = '0;
        pair    = '0;
        shifted = '0;
        for (int m = 0; m < EM; m++) begin
            ring    = r_ctx.row_ofs + SH'(m);
            pair    = {raw[{1'b1, ring, {SH{1'b0}}} +: EM], raw[{1'b0, ring, {SH{1'b0}}} +: EM]};
            shifted = pair >> r_ctx.col_ofs;
            win[m*EM +: EM] = shifted[EM-1:0];
        end
    end

    assign o_busy    = r_valid;
    assign o_push    = r_valid;
    assign o_res.fg  = win[0] && (&(win | ~r_ctx.emask)) && !r_ctx.oob;
    assign o_res.last = r_ctx.last;

endmodule

>>> hw/rtl/bero_queue.sv
// ----------------------------------------------------------------------------
// bero_queue
// Small result queue between the window test and the output stream.
// ----------------------------------------------------------------------------
module bero_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bero_pkg::t_res              i_res,
    input  logic                        i_ready,
    output logic                        o_valid,
    output bero_pkg::t_res              o_res,
    output logic [bero_pkg::QCNT_W-1:0] o_count
);

    localparam int QW = bero_pkg::QPTR_W;
    localparam int CW = bero_pkg::QCNT_W;

    bero_pkg::t_res r_q [bero_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wptr, n_wptr;
    logic [QW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_cnt,  n_cnt;
    logic           pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rptr];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr = i_push ? r_wptr + QW'(1) : r_wptr;
        n_rptr = pop ? r_rptr + QW'(1) : r_rptr;
        n_cnt  = r_cnt + CW'(i_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> hw/rtl/binary_erosion_top.sv
// A result passes from the evaluator's registered store read to the queue.
// Throughput: one input beat per clock while the result queue has room; each
// result reads two store words in the same cycle its input beat is accepted.
// Reset: synchronous, active low; clears counters, result queue and config
// registers to their defaults; the column store is not cleared.
// ----------------------------------------------------------------------------
// binary_erosion_top
// Streaming binary erosion with an up to 8x8 element anchored top-left.
// ----------------------------------------------------------------------------
module binary_erosion_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast
);

    localparam int DEPTH = (MAX_COLS - 1) / bero_pkg::ELEM_MAX + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = bero_pkg::WIN_BITS;

    logic                        accept;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [WB-1:0]               wmask;
    logic [WB-1:0]               wdata;
    logic [AW-1:0]               raddr_a;
    logic [AW-1:0]               raddr_b;
    logic [WB-1:0]               rdata_a;
    logic [WB-1:0]               rdata_b;
    bero_pkg::t_ctx              ctx;
    logic                        busy;
    logic                        push;
    bero_pkg::t_res              res;
    bero_pkg::t_res              head;
    logic [bero_pkg::QCNT_W-1:0] q_cnt;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (int'(q_cnt) + int'(busy)) < bero_pkg::QUEUE_DEPTH;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bero_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wmask     (wmask),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_ctx       (ctx)
    );

    bero_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wmask   (wmask),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    bero_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctx     (ctx),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_busy    (busy),
        .o_push    (push),
        .o_res     (res)
    );

    bero_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (head),
        .o_count (q_cnt)
    );

    assign m_axis_tdata = head.fg ? bero_pkg::FG_VALUE : bero_pkg::BG_VALUE;
    assign m_axis_tlast = head.last;

endmodule
